### rtl/core/sdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and constants for the switch debouncer
// Register indexes, reset values, configuration and result structures.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;
  localparam int IntervalW = 16;
  localparam int CountW    = 8;

  localparam logic                 ActiveHighReset = 1'b1;
  localparam logic [IntervalW-1:0] IntervalReset   = 16'd10;
  localparam logic [CountW-1:0]    ThresholdReset  = 8'd5;
  localparam logic [CountW-1:0]    CountMax        = 8'hFF;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ACTIVE_HIGH       = 2'd0,
    CFG_SAMPLE_INTERVAL   = 2'd1,
    CFG_CONFIRM_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                 active_high;
    logic [IntervalW-1:0] sample_interval;
    logic [CountW-1:0]    confirm_threshold;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic press_event;
    logic release_event;
    logic busy;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/sdc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_cfg_regs: configuration register file
// Holds polarity, sample interval and confirm threshold; write-only port.
// ----------------------------------------------------------------------------
module sdc_cfg_regs
  import sdc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                      cfg
);

  // Decode the index and update the addressed register; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high       <= ActiveHighReset;
      cfg.sample_interval   <= IntervalReset;
      cfg.confirm_threshold <= ThresholdReset;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_HIGH:       cfg.active_high       <= cfg_data[0];
        CFG_SAMPLE_INTERVAL:   cfg.sample_interval   <= cfg_data[IntervalW-1:0];
        CFG_CONFIRM_THRESHOLD: cfg.confirm_threshold <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/sdc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_step: debounce state and per-tick update
// Holds the debounced state, window flag, tick divider and confirm count,
// and computes the next state and the result of one tick.
// ----------------------------------------------------------------------------
module sdc_step
  import sdc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic advance,
  input  wire logic level,
  output result_t   result
);

  logic                 debounced;
  logic                 window;
  logic [IntervalW-1:0] divider;
  logic [CountW-1:0]    count;

  logic                 debounced_next;
  logic                 window_next;
  logic [IntervalW-1:0] divider_next;
  logic [CountW-1:0]    count_next;

  logic                 lvl;
  logic                 mismatch;
  logic [IntervalW-1:0] period;
  logic [CountW-1:0]    need;
  logic [IntervalW-1:0] div_inc;
  logic [CountW-1:0]    count_inc;
  logic                 press_ev;
  logic                 release_ev;

  // Normalise polarity and clamp zero settings to one
  assign lvl       = cfg.active_high ? level : ~level;
  assign mismatch  = (lvl != debounced);
  assign period    = (cfg.sample_interval == '0) ? IntervalW'(1) : cfg.sample_interval;
  assign need      = (cfg.confirm_threshold == '0) ? CountW'(1) : cfg.confirm_threshold;
  assign div_inc   = divider + IntervalW'(1);
  assign count_inc = (count == CountMax) ? count : count + CountW'(1);

  // Open, sample, confirm or abort the monitoring window
  always_comb begin
    debounced_next = debounced;
    window_next    = window;
    divider_next   = divider;
    count_next     = count;
    press_ev       = 1'b0;
    release_ev     = 1'b0;
    if (!window) begin
      if (mismatch) begin
        window_next  = 1'b1;
        divider_next = '0;
        count_next   = '0;
      end
    end else begin
      divider_next = div_inc;
      if (div_inc >= period) begin
        divider_next = '0;
        if (mismatch) begin
          count_next = count_inc;
          if (count_inc >= need) begin
            debounced_next = ~debounced;
            press_ev       = ~debounced;
            release_ev     = debounced;
            window_next    = 1'b0;
            count_next     = '0;
          end
        end else begin
          count_next  = '0;
          window_next = 1'b0;
        end
      end
    end
  end

  // Commit the new state on each transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounced <= 1'b0;
      window    <= 1'b0;
      divider   <= '0;
      count     <= '0;
    end else if (advance) begin
      debounced <= debounced_next;
      window    <= window_next;
      divider   <= divider_next;
      count     <= count_next;
    end
  end

  assign result.pressed       = debounced_next;
  assign result.press_event   = press_ev;
  assign result.release_event = release_ev;
  assign result.busy          = window_next;

  // A confirmed press leaves the switch pressed and the window closed
  a_press_sets_state: assert property (@(posedge clk) disable iff (rst)
    advance && press_ev |=> debounced && !window)
    else $error("press event did not leave pressed state");

  // A confirmed release leaves the switch released and the window closed
  a_release_clears_state: assert property (@(posedge clk) disable iff (rst)
    advance && release_ev |=> !debounced && !window)
    else $error("release event did not leave released state");

  // Without an open window the debounced state cannot flip
  a_idle_no_flip: assert property (@(posedge clk) disable iff (rst)
    advance && !window |=> debounced == $past(debounced))
    else $error("state flipped without a window");

  // The state only changes on a transfer
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(debounced) && $stable(window) && $stable(count))
    else $error("state changed without a transfer");

endmodule
`default_nettype wire

### rtl/core/switch_debounce_confirm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// switch_debounce_confirm: switch debouncer with sampled confirmation
// Input register, per-tick state update and result register.
// ----------------------------------------------------------------------------
// One input transfer is one time-base tick carrying the raw pin level, and it
// yields exactly one result: the debounced state, press/release event pulses
// and a busy flag that is high while a monitoring window is open. The block
// takes one tick per clock cycle while the result side does not stall; a tick
// taken passes through the input register and then the result register, from
// which its result leaves once the receiver does not stall. The state update
// is a single 16-bit increment-and-compare plus an 8-bit saturating count
// between those registers. Configuration registers are written through a
// simple write port and should only change while no ticks are in flight.
// ----------------------------------------------------------------------------
module switch_debounce_confirm
  import sdc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 pin_level,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      pressed,
  output logic                      press_event,
  output logic                      release_event,
  output logic                      busy_res
);

  cfg_t    cfg;
  result_t result;
  logic    s1_valid;
  logic    s1_level;
  logic    out_free;
  logic    advance;

  sdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the held tick on whenever the result register can take it
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_level <= pin_level;
    end
  end

  sdc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .level   (s1_level),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pressed       <= result.pressed;
      press_event   <= result.press_event;
      release_event <= result.release_event;
      busy_res      <= result.busy;
    end
  end

  // An event always closes the window
  a_event_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (press_event || release_event) |-> !busy_res)
    else $error("event reported with window still open");

  // Events agree with the reported state
  a_event_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press_event && !pressed) && !(release_event && pressed))
    else $error("event disagrees with debounced state");

  // A held tick is never lost while the result side is free
  a_no_lost_tick: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free |=> out_valid)
    else $error("held tick was dropped");

endmodule
`default_nettype wire

### tb/switch_debounce_confirm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_debounce_confirm_tb: self-checking bench for the switch debouncer
// Feeds pin-level ticks through the valid/stall input channel and checks
// every result transfer against a cycle-free model of the debouncer. The
// register set is rewritten between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module switch_debounce_confirm_tb;
  import sdc_pkg::*;

  localparam logic [CfgIndexW-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffLen = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 pin_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 pressed;
  logic                 press_event;
  logic                 release_event;
  logic                 busy_res;

  switch_debounce_confirm u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pin_level     (pin_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pressed       (pressed),
    .press_event   (press_event),
    .release_event (release_event),
    .busy_res      (busy_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pin levels waiting to be offered, and expected switch results
  logic        pin_q[$];
  result_t     state_q[$];
  int unsigned ticks_sent = 0;
  int unsigned ticks_taken = 0;
  int unsigned rx_count = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  bit          in_taken = 1'b0;
  bit          tx_lazy = 1'b1;
  bit          rx_lazy = 1'b1;
  int          tx_gap = 0;
  int          rx_wait = 0;

  // Model copy of the registers and the debouncer state
  logic                 m_active_high = ActiveHighReset;
  logic [IntervalW-1:0] m_interval = IntervalReset;
  logic [CountW-1:0]    m_threshold = ThresholdReset;
  logic                 m_state = 1'b0;
  logic                 m_window = 1'b0;
  logic [IntervalW-1:0] m_div = '0;
  logic [CountW-1:0]    m_hits = '0;

  // Advance the debouncer model by one tick and queue the result it gives
  task automatic step_debouncer(input logic pin);
    result_t              r;
    logic                 lvl;
    logic [IntervalW-1:0] period;
    logic [CountW-1:0]    need;
    lvl = m_active_high ? pin : ~pin;
    period = (m_interval == '0) ? IntervalW'(1) : m_interval;
    need = (m_threshold == '0) ? CountW'(1) : m_threshold;
    r = '0;
    if (!m_window) begin
      // open a window on any disagreement; the opening tick takes no sample
      if (lvl != m_state) begin
        m_window = 1'b1;
        m_div = '0;
        m_hits = '0;
      end
    end else begin
      m_div = m_div + IntervalW'(1);
      if (m_div >= period) begin
        m_div = '0;
        if (lvl != m_state) begin
          if (m_hits != CountMax) m_hits = m_hits + CountW'(1);
          if (m_hits >= need) begin
            m_state = ~m_state;
            r.press_event = m_state;
            r.release_event = ~m_state;
            m_window = 1'b0;
            m_hits = '0;
          end
        end else begin
          // sample agrees with the debounced state: abort the window
          m_hits = '0;
          m_window = 1'b0;
        end
      end
    end
    r.pressed = m_state;
    r.busy = m_window;
    state_q.push_back(r);
  endtask

  function automatic void check_bit(string what, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %b actual %b", $time, what, want, got);
      errors++;
    end
  endfunction

  function automatic void offer_pin(logic pin);
    pin_q.push_back(pin);
    ticks_sent++;
  endfunction

  // Sender: hold a stalled transfer, otherwise wait out the gap and offer the next tick
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        tx_gap = tx_lazy ? $urandom_range(0, 5) : 0;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pin_q.size() > 0) begin
        pin_level <= pin_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall for the drawn number of cycles after each transfer
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Track register writes and input transfers in the model, check result transfers
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ACTIVE_HIGH:       m_active_high = cfg_data[0];
          CFG_SAMPLE_INTERVAL:   m_interval = cfg_data[IntervalW-1:0];
          CFG_CONFIRM_THRESHOLD: m_threshold = cfg_data[CountW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        step_debouncer(pin_level);
        ticks_taken++;
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (state_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %b%b%b%b", $time,
                   pressed, press_event, release_event, busy_res);
          errors++;
        end else begin
          want = state_q.pop_front();
          check_bit("pressed", want.pressed, pressed);
          check_bit("press_event", want.press_event, press_event);
          check_bit("release_event", want.release_event, release_event);
          check_bit("busy_res", want.busy, busy_res);
        end
        rx_count++;
        // now and then hold off for a long stretch so the block backs up
        if (rx_count % 700 == 350) rx_wait = HoldOffLen;
        else rx_wait = rx_lazy ? $urandom_range(0, 5) : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("switch_debounce_confirm_tb NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    while (ticks_taken != ticks_sent || state_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three registers, then poke the unused index, which must be ignored
  task automatic set_config(input logic ah, input logic [IntervalW-1:0] iv,
                            input logic [CountW-1:0] th);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ACTIVE_HIGH;
    cfg_data <= {junk[CfgDataW-1:1], ah};
    @(negedge clk);
    cfg_index <= CFG_SAMPLE_INTERVAL;
    cfg_data <= iv;
    @(negedge clk);
    cfg_index <= CFG_CONFIRM_THRESHOLD;
    cfg_data <= {junk[CfgDataW-1:CountW], th};
    @(negedge clk);
    cfg_index <= CfgIdxUnused;
    cfg_data <= CfgDataW'($urandom);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Queue mostly clean presses and releases with contact bounce, plus broken ones and noise
  task automatic queue_bouncy(input int n, input logic ah, input logic [IntervalW-1:0] iv,
                              input logic [CountW-1:0] th);
    int   pushed;
    int   kind;
    int   len;
    int   period;
    int   need;
    logic raw_hold;
    period = (iv == '0) ? 1 : int'(iv);
    need = (th == '0) ? 1 : int'(th);
    raw_hold = ah ? m_state : ~m_state;
    pushed = 0;
    while (pushed < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = $urandom_range(0, 4);
        repeat (len) offer_pin(1'($urandom_range(0, 1)));
        pushed += len;
        raw_hold = ~raw_hold;
        len = period * need + $urandom_range(0, 2 * period);
        repeat (len) offer_pin(raw_hold);
        pushed += len;
      end else if (kind < 9) begin
        // too short to confirm, then drop back so the window aborts
        len = $urandom_range(1, period * need);
        repeat (len) offer_pin(~raw_hold);
        pushed += len;
        repeat (period + 1) offer_pin(raw_hold);
        pushed += period + 1;
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) offer_pin(1'($urandom_range(0, 1)));
        pushed += len;
      end
    end
  endtask

  initial begin
    logic                 ah;
    logic [IntervalW-1:0] iv;
    logic [CountW-1:0]    th;
    int                   n;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: open a window and leave it open
    offer_pin(1'b0); offer_pin(1'b0); offer_pin(1'b1);
    offer_pin(1'b1); offer_pin(1'b0); offer_pin(1'b0);
    wait_drained();

    // Zero interval and zero threshold, changed while the window is open
    set_config(1'b1, '0, '0);
    offer_pin(1'b1); offer_pin(1'b1); offer_pin(1'b0);
    offer_pin(1'b1); offer_pin(1'b0); offer_pin(1'b0);
    wait_drained();

    // Active-low pin
    set_config(1'b0, IntervalW'(1), CountW'(1));
    offer_pin(1'b0); offer_pin(1'b0); offer_pin(1'b1); offer_pin(1'b1);
    wait_drained();

    // Largest interval and threshold, then the interval dropped under the divider
    set_config(1'b1, '1, '1);
    offer_pin(1'b1); offer_pin(1'b1); offer_pin(1'b1); offer_pin(1'b1);
    wait_drained();
    set_config(1'b1, IntervalW'(2), '1);
    offer_pin(1'b1); offer_pin(1'b1); offer_pin(1'b0);
    wait_drained();

    // Random phases over a spread of settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      tx_lazy = (ph % 3) != 1;
      rx_lazy = (ph % 3) != 2;
      n = 170;
      case (ph)
        0: begin ah = 1'b1; iv = IntervalW'(1); th = CountW'(3); end
        1: begin ah = 1'b0; iv = IntervalW'(2); th = CountW'(4); end
        2: begin ah = 1'b1; iv = '0; th = '0; end
        3: begin ah = 1'b1; iv = IntervalW'(1); th = '1; n = 340; end
        4: begin ah = 1'b0; iv = IntervalW'(3); th = CountW'(2); end
        5: begin
          ah = 1'b1;
          iv = IntervalW'($urandom_range(1, 4));
          th = CountW'($urandom_range(1, 6));
        end
        6: begin
          ah = 1'b0;
          iv = IntervalW'($urandom_range(5, 40));
          th = CountW'($urandom_range(1, 3));
        end
        default: begin
          ah = 1'($urandom_range(0, 1));
          iv = IntervalW'($urandom_range(0, 3));
          th = CountW'($urandom_range(0, 5));
        end
      endcase
      set_config(ah, iv, th);
      queue_bouncy(n, ah, iv, th);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && state_q.size() == 0) begin
      $display("switch_debounce_confirm_tb OK");
    end else begin
      $display("switch_debounce_confirm_tb NOT OK");
    end
    $finish;
  end

endmodule
